// ----- rtl/abdq_pkg.sv -----
// ----------------------------------------------------------------------------
// abdq_pkg
// Shared constants and the arctangent table for the alpha-beta to d-q
// rotation pipeline.
// ----------------------------------------------------------------------------
package abdq_pkg;

   // Full turn as a 32-bit binary angle; top two bits give the quadrant
   localparam int TURN_WIDTH   = 32;
   localparam int TRIG_FRAC    = 30;
   // CORDIC datapath: Q2.30 with headroom
   localparam int CORDIC_WIDTH = 34;
   // Residual angle: signed, 2^-32 turn units
   localparam int RESID_WIDTH  = 33;
   localparam int ATAN_IDX_W   = 5;

   typedef logic signed [CORDIC_WIDTH-1:0] cordic_type;
   typedef logic signed [RESID_WIDTH-1:0]  resid_type;
   typedef logic [1:0]                     quad_type;

   localparam cordic_type INV_GAIN = CORDIC_WIDTH'(32'h26DD3B6A);

   localparam quad_type QUAD_0 = 2'd0;
   localparam quad_type QUAD_1 = 2'd1;
   localparam quad_type QUAD_2 = 2'd2;
   localparam quad_type QUAD_3 = 2'd3;

   // atan(2^-i) in units of 2^-32 turn, truncated
   function automatic logic [31:0] arctan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] val;
      begin
         case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051D;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2E;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2F9;
            5'd15:   val = 32'h0000517C;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A2F;
            5'd19:   val = 32'h00000517;
            5'd20:   val = 32'h0000028B;
            5'd21:   val = 32'h00000145;
            5'd22:   val = 32'h000000A2;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000028;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000002;
            5'd29:   val = 32'h00000001;
            default: val = 32'h00000000;
         endcase
         return val;
      end
   endfunction

endpackage

// ----- rtl/alpha_beta_to_dq_rotation.sv -----
// ----------------------------------------------------------------------------
// alpha_beta_to_dq_rotation
// Park rotation of a stationary-frame sample (alpha, beta) into the rotating
// frame (d, q), using a pipelined gain-compensated CORDIC for sin/cos.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the skid is empty; after the capture
// register, one CORDIC stage per register, then a quadrant stage, a product
// stage and a sum/round stage.
// A two-sided output: a skid register catches the last word when rsp_ready is
// low, so req_ready comes straight from a flop.
// Reset (synchronous, active high) clears all valid bits and the skid.
module alpha_beta_to_dq_rotation
   import abdq_pkg::*;
#(
   parameter int SAMPLE_WIDTH    = 16,
   parameter int ANGLE_WIDTH     = 16,
   parameter int ROTATION_STAGES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_alpha_in,
   input  logic signed [SAMPLE_WIDTH-1:0] req_beta_in,
   input  logic        [ANGLE_WIDTH-1:0]  req_angle_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH:0]   rsp_d_out,
   output logic signed [SAMPLE_WIDTH:0]   rsp_q_out
);

   localparam int N      = ROTATION_STAGES;
   localparam int PROD_W = SAMPLE_WIDTH + CORDIC_WIDTH;
   localparam int SUM_W  = PROD_W + 1;
   localparam int OUT_W  = SAMPLE_WIDTH + 1;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]       prod_type;
   typedef logic signed [SUM_W-1:0]        sum_type;
   typedef logic signed [OUT_W-1:0]        result_type;

   localparam sum_type ROUND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);

   logic skid_valid_ff, skid_valid_in;

   // Whole pipeline advances together; it halts only while the skid is full
   logic advance;
   assign advance   = ~skid_valid_ff;
   assign req_ready = advance;

   // ------------------------------------------------------------------
   // Input capture and CORDIC stages (index 0 is the capture register)
   // ------------------------------------------------------------------
   logic       valid_ff [0:N];
   cordic_type x_ff     [0:N];
   cordic_type y_ff     [0:N];
   resid_type  z_ff     [0:N];
   quad_type   quad_ff  [0:N];
   sample_type a_ff     [0:N];
   sample_type b_ff     [0:N];

   logic [TURN_WIDTH-1:0] turn;
   assign turn = TURN_WIDTH'(req_angle_in) << (TURN_WIDTH - ANGLE_WIDTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid;
      end
      if (advance) begin
         // Top two bits pick the quadrant; the rest is the first-quadrant angle
         x_ff[0]    <= INV_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= RESID_WIDTH'(turn[TURN_WIDTH-3:0]);
         quad_ff[0] <= turn[TURN_WIDTH-1 -: 2];
         a_ff[0]    <= req_alpha_in;
         b_ff[0]    <= req_beta_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_cordic
      cordic_type x_in, y_in, dx, dy;
      resid_type  z_in, step;

      always_comb begin
         // Arithmetic shift floors, as the rotation needs
         dx   = y_ff[i] >>> i;
         dy   = x_ff[i] >>> i;
         step = RESID_WIDTH'(arctan_turn(ATAN_IDX_W'(i)));
         if (!z_ff[i][RESID_WIDTH-1]) begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
            z_in = z_ff[i] - step;
         end else begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
            z_in = z_ff[i] + step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[i+1] <= valid_ff[i];
         end
         if (advance) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            quad_ff[i+1] <= quad_ff[i];
            a_ff[i+1]    <= a_ff[i];
            b_ff[i+1]    <= b_ff[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Quadrant fold: map first-quadrant (cos, sin) onto the full turn
   // ------------------------------------------------------------------
   logic       map_valid_ff;
   cordic_type cos_ff, sin_ff, cos_in, sin_in;
   sample_type map_a_ff, map_b_ff;

   always_comb begin
      case (quad_ff[N])
         QUAD_0: begin
            cos_in = x_ff[N];
            sin_in = y_ff[N];
         end
         QUAD_1: begin
            cos_in = -y_ff[N];
            sin_in = x_ff[N];
         end
         QUAD_2: begin
            cos_in = -x_ff[N];
            sin_in = -y_ff[N];
         end
         default: begin
            cos_in = y_ff[N];
            sin_in = -x_ff[N];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else if (advance) begin
         map_valid_ff <= valid_ff[N];
      end
      if (advance) begin
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
         map_a_ff <= a_ff[N];
         map_b_ff <= b_ff[N];
      end
   end

   // ------------------------------------------------------------------
   // Products: four multipliers, registered before the sums
   // ------------------------------------------------------------------
   logic     mul_valid_ff;
   prod_type ac_ff, bs_ff, bc_ff, as_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (advance) begin
         mul_valid_ff <= map_valid_ff;
      end
      if (advance) begin
         ac_ff <= PROD_W'(map_a_ff) * PROD_W'(cos_ff);
         bs_ff <= PROD_W'(map_b_ff) * PROD_W'(sin_ff);
         bc_ff <= PROD_W'(map_b_ff) * PROD_W'(cos_ff);
         as_ff <= PROD_W'(map_a_ff) * PROD_W'(sin_ff);
      end
   end

   // ------------------------------------------------------------------
   // Sum and round half up back to the sample scale
   // ------------------------------------------------------------------
   logic       sum_valid_ff;
   sum_type    d_sum, q_sum;
   result_type d_ff, q_ff;

   always_comb begin
      d_sum = SUM_W'(ac_ff) + SUM_W'(bs_ff) + ROUND_HALF;
      q_sum = SUM_W'(bc_ff) - SUM_W'(as_ff) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= mul_valid_ff;
      end
      if (advance) begin
         d_ff <= d_sum[TRIG_FRAC +: OUT_W];
         q_ff <= q_sum[TRIG_FRAC +: OUT_W];
      end
   end

   // ------------------------------------------------------------------
   // Skid register: catch the last word when the consumer stalls
   // ------------------------------------------------------------------
   result_type skid_d_ff, skid_q_ff;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // Drop the held word once taken
         if (rsp_ready) skid_valid_in = 1'b0;
      end else if (sum_valid_ff && !rsp_ready) begin
         // Hold the word that the pipeline is about to push past
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
      if (!skid_valid_ff) begin
         skid_d_ff <= d_ff;
         skid_q_ff <= q_ff;
      end
   end

   // Older word in the skid goes first
   assign rsp_valid = skid_valid_ff | sum_valid_ff;
   assign rsp_d_out = skid_valid_ff ? skid_d_ff : d_ff;
   assign rsp_q_out = skid_valid_ff ? skid_q_ff : q_ff;

endmodule
